>>> src/assert_macros.svh
// Assertion macros for the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_ON_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/tsmg_pkg.sv
package tsmg_pkg;

  localparam int unsigned NumMotors = 4;
  localparam int unsigned QueueDepthDefault = 2;
  localparam logic [6:0] ClipLimitReset = 7'd80;
  localparam logic [6:0] MagMax = 7'd127;

  typedef struct packed {
    logic              mode;
    logic signed [15:0] tilt_x;
    logic signed [15:0] tilt_y;
  } tsmg_request_t;

  typedef struct packed {
    logic [1:0] motor_index;
    logic [7:0] move_code;
    logic       last;
  } tsmg_command_t;

  typedef struct packed {
    logic [NumMotors-1:0]      neg;
    logic [NumMotors-1:0][7:0] mag;
  } tsmg_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tsmg_q_status_t;

  function automatic logic signed [16:0] halve(input logic signed [15:0] v);
    logic signed [16:0] t;
    t = {v[15], v} + 17'(v[15]);
    return t >>> 1;
  endfunction

  function automatic logic signed [7:0] clip(input logic signed [16:0] v,
                                             input logic [6:0] lim);
    logic signed [16:0] l;
    l = $signed({10'b0, lim});
    if (v > l) begin
      return $signed({1'b0, lim});
    end else if (v < -l) begin
      return 8'(-l);
    end else begin
      return v[7:0];
    end
  endfunction

endpackage

>>> src/tsmg_queue.sv
module tsmg_queue #(
  parameter int unsigned Depth = tsmg_pkg::QueueDepthDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr,
  input  tsmg_pkg::tsmg_job_t      wr_data,
  input  logic                     rd,
  output tsmg_pkg::tsmg_job_t      rd_data,
  output tsmg_pkg::tsmg_q_status_t status
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  tsmg_pkg::tsmg_job_t entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign status.full  = (count == CntW'(Depth));
  assign status.empty = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/tsmg_front.sv
module tsmg_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clip_limit_write,
  input  logic [6:0]               clip_limit,
  input  logic                     push,
  output logic                     full,
  input  tsmg_pkg::tsmg_request_t  request,
  input  tsmg_pkg::tsmg_q_status_t q_status,
  output logic                     q_push,
  output tsmg_pkg::tsmg_job_t      q_data
);

  localparam int unsigned N = tsmg_pkg::NumMotors;

  logic [6:0] limit;
  logic s1_valid;
  logic s1_mode;
  logic signed [7:0] s1_target [N];
  logic signed [7:0] pos [N];

  logic signed [16:0] tx;
  logic signed [16:0] ty;
  logic signed [16:0] hx;
  logic signed [16:0] hy;
  logic signed [16:0] raw [N];
  logic [8:0] delta [N];
  logic [8:0] delta_neg [N];
  logic any_move;
  logic need_push;
  logic go;
  logic accept;

  always_comb begin
    tx = {request.tilt_x[15], request.tilt_x};
    ty = {request.tilt_y[15], request.tilt_y};
    hx = tsmg_pkg::halve(request.tilt_x);
    hy = tsmg_pkg::halve(request.tilt_y);
    raw[0] = tx - hx;
    raw[1] = ty - hy;
    raw[2] = 17'sd0 - hx;
    raw[3] = 17'sd0 - hy;
  end

  always_comb begin
    any_move = 1'b0;
    for (int i = 0; i < N; i++) begin
      delta[i] = {s1_target[i][7], s1_target[i]} - {pos[i][7], pos[i]};
      delta_neg[i] = 9'd0 - delta[i];
      q_data.neg[i] = delta[i][8];
      q_data.mag[i] = delta[i][8] ? delta_neg[i][7:0] : delta[i][7:0];
      if (delta[i] != '0) begin
        any_move = 1'b1;
      end
    end
  end

  assign need_push = s1_valid && !s1_mode && any_move;
  assign go        = s1_valid && (!need_push || !q_status.full);
  assign full      = s1_valid && !go;
  assign accept    = push && !full;
  assign q_push    = go && need_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= tsmg_pkg::ClipLimitReset;
    end else if (clip_limit_write) begin
      limit <= clip_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode <= request.mode;
      for (int i = 0; i < N; i++) begin
        s1_target[i] <= tsmg_pkg::clip(raw[i], limit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        pos[i] <= '0;
      end
    end else if (go) begin
      for (int i = 0; i < N; i++) begin
        pos[i] <= s1_mode ? 8'sd0 : s1_target[i];
      end
    end
  end

endmodule

>>> src/tsmg_back.sv
module tsmg_back (
  input  logic                     clk,
  input  logic                     rst,
  input  tsmg_pkg::tsmg_q_status_t q_status,
  input  tsmg_pkg::tsmg_job_t      q_data,
  output logic                     q_pop,
  output logic                     empty,
  input  logic                     pop,
  output tsmg_pkg::tsmg_command_t  command
);

  localparam int unsigned N = tsmg_pkg::NumMotors;

  logic busy;
  logic [N-1:0] neg;
  logic [7:0] rem [N];
  logic out_valid;
  tsmg_pkg::tsmg_command_t out_cmd;

  logic emit;
  logic found;
  logic later;
  logic [1:0] sel;
  logic [6:0] step;
  logic [7:0] rem_after;
  logic last_cmd;

  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (rem[i] != '0) begin
        found = 1'b1;
        sel   = 2'(i);
      end
    end
    later = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (2'(i) > sel && rem[i] != '0) begin
        later = 1'b1;
      end
    end
    step      = (rem[sel] > {1'b0, tsmg_pkg::MagMax}) ? tsmg_pkg::MagMax : rem[sel][6:0];
    rem_after = rem[sel] - {1'b0, step};
    last_cmd  = (rem_after == '0) && !later;
  end

  assign emit  = busy && found && (!out_valid || pop);
  assign q_pop = (!busy || (emit && last_cmd)) && !q_status.empty;
  assign empty = !out_valid;
  assign command = out_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (q_pop) begin
      busy <= 1'b1;
    end else if (emit && last_cmd) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      neg <= q_data.neg;
      for (int i = 0; i < N; i++) begin
        rem[i] <= q_data.mag[i];
      end
    end else if (emit) begin
      rem[sel] <= rem_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_cmd.motor_index <= sel;
      out_cmd.move_code   <= {neg[sel], step};
      out_cmd.last        <= last_cmd;
    end
  end

endmodule

>>> src/tiptilt_stepper_move_generator.sv
// Splits each tip/tilt request across four actuators and issues sign-magnitude
// move commands, actuator 0 first, with last set on the final command of a
// request; a homing request or a request that moves nothing issues no command.
// A front end computes clipped targets and deltas and can take one request
// per cycle while the job queue (QueueDepth entries) has room. The back end
// issues one command per cycle while its output register is empty or popped;
// a request has from one to eight commands, which sets the sustained rate.
// Results sit in an output register refilled in the cycle it is popped. A
// request's first command passes the front-end stage, job queue, back-end job
// registers and output register. Writes to clip_limit apply to later requests.
`include "assert_macros.svh"

module tiptilt_stepper_move_generator #(
  parameter int unsigned QueueDepth = tsmg_pkg::QueueDepthDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clip_limit_write,
  input  logic [6:0]              clip_limit,
  input  logic                    push,
  output logic                    full,
  input  tsmg_pkg::tsmg_request_t request,
  output logic                    empty,
  input  logic                    pop,
  output tsmg_pkg::tsmg_command_t command
);

  logic q_push;
  logic q_pop;
  tsmg_pkg::tsmg_job_t q_wr_data;
  tsmg_pkg::tsmg_job_t q_rd_data;
  tsmg_pkg::tsmg_q_status_t q_status;

  tsmg_front u_front (
    .clk              (clk),
    .rst              (rst),
    .clip_limit_write (clip_limit_write),
    .clip_limit       (clip_limit),
    .push             (push),
    .full             (full),
    .request          (request),
    .q_status         (q_status),
    .q_push           (q_push),
    .q_data           (q_wr_data)
  );

  tsmg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wr_data),
    .rd      (q_pop),
    .rd_data (q_rd_data),
    .status  (q_status)
  );

  tsmg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_data   (q_rd_data),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .command  (command)
  );

  `ASSERT_ALWAYS(a_empty_after_reset, clk, rst |=> empty, "results present after reset")
  `ASSERT_ON_CLK(a_no_push_when_full, clk, rst, q_push |-> !q_status.full, "job queue overrun")
  `ASSERT_ON_CLK(a_no_pop_when_empty, clk, rst, q_pop |-> !q_status.empty, "job queue underrun")

endmodule
